[sv/clnd_pkg.sv]
// Package for the character LCD nibble bus driver: codes, reset values and nibble selection.
`default_nettype none
package clnd_pkg;

	localparam int TMR_W  = 20;
	localparam int CFG_W  = 20;
	localparam int IDX_W  = 3;
	localparam int STEP_W = 4;

	// operation codes
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_INIT  = 1'b1;

	// register indexes
	localparam logic [IDX_W-1:0] REG_ENABLE_HIGH  = 3'd0;
	localparam logic [IDX_W-1:0] REG_SETUP        = 3'd1;
	localparam logic [IDX_W-1:0] REG_POWER_ON     = 3'd2;
	localparam logic [IDX_W-1:0] REG_FUNCTION_SET = 3'd3;
	localparam logic [IDX_W-1:0] REG_DISPLAY_CTRL = 3'd4;
	localparam logic [IDX_W-1:0] REG_ENTRY_MODE   = 3'd5;

	localparam logic [19:0] RST_ENABLE_HIGH  = 20'd50000;
	localparam logic [9:0]  RST_SETUP        = 10'd1;
	localparam logic [19:0] RST_POWER_ON     = 20'd50000;
	localparam logic [7:0]  RST_FUNCTION_SET = 8'h28;
	localparam logic [7:0]  RST_DISPLAY_CTRL = 8'h0C;
	localparam logic [7:0]  RST_ENTRY_MODE   = 8'h06;

	localparam logic [7:0] CLEAR_CMD   = 8'h01;
	localparam logic [3:0] INIT_NIB_A  = 4'h3;
	localparam logic [3:0] INIT_NIB_B  = 4'h2;

	localparam logic [STEP_W-1:0] INIT_LAST_STEP  = 4'd11;
	localparam logic [STEP_W-1:0] WRITE_LAST_STEP = 4'd1;
	localparam logic [STEP_W-1:0] INIT_BYTE_BASE  = 4'd4;

	typedef struct packed {
		logic             load;
		logic [TMR_W-1:0] us;
	} tmr_cmd_t;

	// nibble driven at a given step of a write or of the init sequence
	function automatic logic [3:0] nibble_sel(
		input logic              op,
		input logic [STEP_W-1:0] step,
		input logic [7:0]        data_byte,
		input logic [7:0]        fs_cmd,
		input logic [7:0]        dc_cmd,
		input logic [7:0]        em_cmd
	);
		logic [STEP_W-1:0] rel;
		logic [7:0]        sel_byte;
		rel      = step - INIT_BYTE_BASE;
		sel_byte = data_byte;
		if (op == OP_INIT) begin
			case (rel[2:1])
				2'd0:    sel_byte = fs_cmd;
				2'd1:    sel_byte = dc_cmd;
				2'd2:    sel_byte = CLEAR_CMD;
				default: sel_byte = em_cmd;
			endcase
			if (step < INIT_BYTE_BASE - 4'd1) begin
				return INIT_NIB_A;
			end else if (step == INIT_BYTE_BASE - 4'd1) begin
				return INIT_NIB_B;
			end
		end
		// high nibble on even steps
		return step[0] ? sel_byte[3:0] : sel_byte[7:4];
	endfunction

endpackage
`default_nettype wire

[sv/clnd_if.sv]
// Stream interfaces: command items in, strobed nibble results out.
`default_nettype none
interface clnd_cmd_if;
	logic       valid;
	logic       ready;
	logic       operation;
	logic       reg_select;
	logic [7:0] data_byte;

	modport source (output valid, operation, reg_select, data_byte, input ready);
	modport sink   (input valid, operation, reg_select, data_byte, output ready);
endinterface

interface clnd_nib_if;
	logic       valid;
	logic       ready;
	logic       rs_level;
	logic [3:0] nibble;
	logic       last;

	modport source (output valid, rs_level, nibble, last, input ready);
	modport sink   (input valid, rs_level, nibble, last, output ready);
endinterface
`default_nettype wire

[sv/clnd_timer.sv]
// Shared microsecond wait timer: prescaler plus microsecond down-counter.
`default_nettype none
module clnd_timer
	import clnd_pkg::*;
#(
	parameter int CYCLES_PER_US = 48
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire tmr_cmd_t cmd,
	output logic          expired
);
	localparam int PRE_W = (CYCLES_PER_US > 1) ? $clog2(CYCLES_PER_US) : 1;
	localparam logic [PRE_W-1:0] PRE_LAST = PRE_W'(CYCLES_PER_US - 1);

	logic [TMR_W-1:0] us_q;
	logic [PRE_W-1:0] pre_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			us_q  <= '0;
			pre_q <= '0;
		end else if (cmd.load) begin
			us_q  <= cmd.us;
			pre_q <= '0;
		end else if (us_q != '0) begin
			if (pre_q == PRE_LAST) begin
				pre_q <= '0;
				us_q  <= us_q - TMR_W'(1);
			end else begin
				pre_q <= pre_q + PRE_W'(1);
			end
		end
	end

	assign expired = (us_q == '0);
endmodule
`default_nettype wire

[sv/char_lcd_nibble_bus_driver_core.sv]
// Character LCD 4-bit bus driver: sequencer, configuration registers and result register.
//
// Usage: items arrive on cmd (valid/ready). operation 0 writes data_byte with RS =
// reg_select as two nibbles, high first; operation 1 runs the power-on init: wait
// power_on_wait_us, nibbles 3,3,3,2, then function set, display control, clear and
// entry mode bytes. Each strobed nibble leaves as one beat on nib, with last set on
// the final beat of the item. Configuration is written through cfg_wr_en/cfg_index/
// cfg_wdata only while idle, a rule for the user that the block does not enforce;
// writes to an index beyond the list are dropped. Each nibble waits setup_us in RS
// setup, data setup and E low and enable_high_us with E high, all counted by the one
// shared wait timer. An init first waits power_on_wait_us and runs 12 nibbles.
// cmd.ready is high only between items; one item is in work at a time.
// A result waits in an output register; if nib stalls, the sequencer holds before
// the next nibble until the register is free, and the last result of an item may
// still wait while the next item is accepted.
// Reset: registers take their defaults, the sequencer goes idle, no beat is pending.
`default_nettype none
module char_lcd_nibble_bus_driver_core
	import clnd_pkg::*;
#(
	parameter int CYCLES_PER_US = 48
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_wr_en,
	input  wire logic [IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0] cfg_wdata,
	clnd_cmd_if.sink              cmd,
	clnd_nib_if.source            nib
);
	typedef enum logic [6:0] {
		ST_IDLE       = 7'b0000001,
		ST_POWER_WAIT = 7'b0000010,
		ST_RS_SETUP   = 7'b0000100,
		ST_DATA_SETUP = 7'b0001000,
		ST_E_HIGH     = 7'b0010000,
		ST_E_LOW      = 7'b0100000,
		ST_EMIT       = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	logic [19:0] enable_high_q;
	logic [9:0]  setup_q;
	logic [19:0] power_on_q;
	logic [7:0]  fs_cmd_q, dc_cmd_q, em_cmd_q;

	logic              op_q, rs_q;
	logic [7:0]        byte_q;
	logic [STEP_W-1:0] step_q, last_step_q;

	logic       out_valid_q, out_rs_q, out_last_q;
	logic [3:0] out_nib_q;

	tmr_cmd_t tmr_cmd;
	logic     expired;
	logic     accept, out_free, out_load, at_last;

	clnd_timer #(.CYCLES_PER_US(CYCLES_PER_US)) u_timer (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (tmr_cmd),
		.expired (expired)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_high_q <= RST_ENABLE_HIGH;
			setup_q       <= RST_SETUP;
			power_on_q    <= RST_POWER_ON;
			fs_cmd_q      <= RST_FUNCTION_SET;
			dc_cmd_q      <= RST_DISPLAY_CTRL;
			em_cmd_q      <= RST_ENTRY_MODE;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_ENABLE_HIGH:  enable_high_q <= cfg_wdata[19:0];
				REG_SETUP:        setup_q       <= cfg_wdata[9:0];
				REG_POWER_ON:     power_on_q    <= cfg_wdata[19:0];
				REG_FUNCTION_SET: fs_cmd_q      <= cfg_wdata[7:0];
				REG_DISPLAY_CTRL: dc_cmd_q      <= cfg_wdata[7:0];
				REG_ENTRY_MODE:   em_cmd_q      <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	assign cmd.ready = (state_q == ST_IDLE);
	assign accept    = cmd.valid && cmd.ready;
	assign out_free  = !out_valid_q || nib.ready;
	assign out_load  = (state_q == ST_EMIT) && out_free;
	assign at_last   = (step_q == last_step_q);

	always_comb begin
		state_d     = state_q;
		tmr_cmd     = '{load: 1'b0, us: TMR_W'(setup_q)};
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					tmr_cmd.load = 1'b1;
					if (cmd.operation == OP_INIT) begin
						tmr_cmd.us = power_on_q;
						state_d    = ST_POWER_WAIT;
					end else begin
						state_d    = ST_RS_SETUP;
					end
				end
			end
			ST_POWER_WAIT: begin
				if (expired) begin
					tmr_cmd.load = 1'b1;
					state_d      = ST_RS_SETUP;
				end
			end
			ST_RS_SETUP: begin
				if (expired) begin
					tmr_cmd.load = 1'b1;
					state_d      = ST_DATA_SETUP;
				end
			end
			ST_DATA_SETUP: begin
				if (expired) begin
					tmr_cmd.load = 1'b1;
					tmr_cmd.us   = enable_high_q;
					state_d      = ST_E_HIGH;
				end
			end
			ST_E_HIGH: begin
				if (expired) begin
					tmr_cmd.load = 1'b1;
					state_d      = ST_E_LOW;
				end
			end
			ST_E_LOW: begin
				if (expired) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					if (at_last) begin
						state_d = ST_IDLE;
					end else begin
						tmr_cmd.load = 1'b1;
						state_d      = ST_RS_SETUP;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				step_q <= '0;
			end else if (out_load && !at_last) begin
				step_q <= step_q + STEP_W'(1);
			end
		end
	end

	// item fields, held for the whole sequence
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q        <= cmd.operation;
			rs_q        <= (cmd.operation == OP_INIT) ? 1'b0 : cmd.reg_select;
			byte_q      <= cmd.data_byte;
			last_step_q <= (cmd.operation == OP_INIT) ? INIT_LAST_STEP : WRITE_LAST_STEP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (nib.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_rs_q   <= rs_q;
			out_nib_q  <= nibble_sel(op_q, step_q, byte_q, fs_cmd_q, dc_cmd_q, em_cmd_q);
			out_last_q <= at_last;
		end
	end

	assign nib.valid    = out_valid_q;
	assign nib.rs_level = out_rs_q;
	assign nib.nibble   = out_nib_q;
	assign nib.last     = out_last_q;

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != ST_IDLE)
		else $error("sequencer idle right after accepting an item");

	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> (step_q <= last_step_q))
		else $error("nibble step beyond the end of the item");

	a_last_frees_input: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && at_last) |=> cmd.ready && nib.valid && nib.last)
		else $error("final nibble did not return the sequencer to idle");
`endif
endmodule
`default_nettype wire

[test/tb.sv]
// Testbench for the character LCD nibble bus driver: random and directed items, checked per beat.
`timescale 1ns / 1ps
`default_nettype none
module tb;
	import clnd_pkg::*;

	localparam int CPU_US    = 2;
	localparam int LIMIT     = 2_000_000;
	localparam int LONG_HOLD = 400;

	typedef struct packed {
		logic       op;
		logic       rs;
		logic [7:0] data;
	} lcd_cmd_t;

	typedef struct packed {
		logic       rs;
		logic [3:0] nib;
		logic       last;
	} strobe_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b1;
	logic             cfg_wr_en;
	logic [IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_wdata;

	clnd_cmd_if cmd_bus();
	clnd_nib_if nib_bus();

	char_lcd_nibble_bus_driver_core #(.CYCLES_PER_US(CPU_US)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd_bus),
		.nib       (nib_bus)
	);

	lcd_cmd_t cmds_waiting[$];
	strobe_t  strobes_due[$];

	// mirror of the register file
	logic [19:0] en_high_us = RST_ENABLE_HIGH;
	logic [9:0]  setup_us   = RST_SETUP;
	logic [19:0] power_us   = RST_POWER_ON;
	logic [7:0]  fs_cmd     = RST_FUNCTION_SET;
	logic [7:0]  dc_cmd     = RST_DISPLAY_CTRL;
	logic [7:0]  em_cmd     = RST_ENTRY_MODE;

	int          mismatches = 0;
	int unsigned cycles = 0;
	bit          src_idle_on = 1'b0;
	bit          sink_idle_on = 1'b0;
	int          stall_requests = 0;
	int          stalls_started;
	int          hold_left;
	int          src_gap;
	int          sink_gap;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	task automatic note_mismatch(input string what);
		$display("ERROR @%0t: %s", $time, what);
		mismatches++;
	endtask

	function automatic void predict_strobes(input lcd_cmd_t c);
		logic [3:0] nibs[12];
		logic [7:0] init_bytes[4];
		int         n;
		strobe_t    s;
		n = 0;
		if (c.op == OP_WRITE) begin
			nibs[0] = c.data[7:4];
			nibs[1] = c.data[3:0];
			n = 2;
		end else begin
			init_bytes = '{fs_cmd, dc_cmd, CLEAR_CMD, em_cmd};
			nibs[0] = INIT_NIB_A;
			nibs[1] = INIT_NIB_A;
			nibs[2] = INIT_NIB_A;
			nibs[3] = INIT_NIB_B;
			for (int j = 0; j < 4; j++) begin
				nibs[4 + 2*j] = init_bytes[j][7:4];
				nibs[5 + 2*j] = init_bytes[j][3:0];
			end
			n = 12;
		end
		for (int i = 0; i < n; i++) begin
			s.rs   = (c.op == OP_WRITE) ? c.rs : 1'b0;
			s.nib  = nibs[i];
			s.last = (i == n - 1);
			strobes_due.push_back(s);
		end
	endfunction

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		case (idx)
			REG_ENABLE_HIGH:  en_high_us = value[19:0];
			REG_SETUP:        setup_us   = value[9:0];
			REG_POWER_ON:     power_us   = value[19:0];
			REG_FUNCTION_SET: fs_cmd     = value[7:0];
			REG_DISPLAY_CTRL: dc_cmd     = value[7:0];
			REG_ENTRY_MODE:   em_cmd     = value[7:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic queue_cmd(input logic op, input logic rs, input logic [7:0] data);
		lcd_cmd_t c;
		c.op   = op;
		c.rs   = rs;
		c.data = data;
		cmds_waiting.push_back(c);
	endtask

	task automatic queue_random(input int n);
		for (int i = 0; i < n; i++)
			queue_cmd(($urandom_range(0, 5) == 0) ? OP_INIT : OP_WRITE,
				1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
	endtask

	// block idle: every beat sent, every nibble back, sequencer taking commands
	task automatic wait_idle();
		do @(negedge clk);
		while (!(cmds_waiting.size() == 0 && !cmd_bus.valid && strobes_due.size() == 0
			&& cmd_bus.ready));
	endtask

	task automatic random_config();
		write_reg(REG_ENABLE_HIGH, CFG_W'($urandom_range(1, 4)));
		write_reg(REG_SETUP, CFG_W'($urandom_range(0, 2)));
		write_reg(REG_POWER_ON, CFG_W'($urandom_range(0, 6)));
		// upper data bits land outside the byte registers and must be dropped
		write_reg(REG_FUNCTION_SET, CFG_W'($urandom_range(0, 20'hFFFFF)));
		write_reg(REG_DISPLAY_CTRL, CFG_W'($urandom_range(0, 20'hFFFFF)));
		write_reg(REG_ENTRY_MODE, CFG_W'($urandom_range(0, 20'hFFFFF)));
	endtask

	// command source
	always @(posedge clk or negedge arst_n) begin : drive_cmd
		int       gap_now;
		lcd_cmd_t nxt;
		if (!arst_n) begin
			cmd_bus.valid      <= 1'b0;
			cmd_bus.operation  <= OP_WRITE;
			cmd_bus.reg_select <= 1'b0;
			cmd_bus.data_byte  <= 8'h00;
			src_gap            <= 0;
		end else begin
			gap_now = src_gap;
			if (cmd_bus.valid && cmd_bus.ready) begin
				nxt.op   = cmd_bus.operation;
				nxt.rs   = cmd_bus.reg_select;
				nxt.data = cmd_bus.data_byte;
				predict_strobes(nxt);
				if (src_idle_on && $urandom_range(0, 3) == 0)
					gap_now = $urandom_range(1, 16);
			end
			if (!cmd_bus.valid || cmd_bus.ready) begin
				if (gap_now != 0) begin
					src_gap       <= gap_now - 1;
					cmd_bus.valid <= 1'b0;
				end else if (cmds_waiting.size() != 0) begin
					nxt = cmds_waiting.pop_front();
					cmd_bus.operation  <= nxt.op;
					cmd_bus.reg_select <= nxt.rs;
					cmd_bus.data_byte  <= nxt.data;
					cmd_bus.valid      <= 1'b1;
				end else begin
					cmd_bus.valid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off, timed here so the source keeps pushing meanwhile
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left      <= 0;
			stalls_started <= 0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (stalls_started != stall_requests) begin
			hold_left      <= LONG_HOLD;
			stalls_started <= stalls_started + 1;
		end
	end

	// nibble sink and checker
	always @(posedge clk or negedge arst_n) begin : watch_nib
		int      gap_now;
		strobe_t want;
		if (!arst_n) begin
			nib_bus.ready <= 1'b0;
			sink_gap      <= 0;
		end else begin
			if (nib_bus.valid && nib_bus.ready) begin
				if (strobes_due.size() == 0) begin
					note_mismatch($sformatf("unexpected beat rs %0b nibble %h last %0b",
						nib_bus.rs_level, nib_bus.nibble, nib_bus.last));
				end else begin
					want = strobes_due.pop_front();
					if (nib_bus.rs_level !== want.rs)
						note_mismatch($sformatf("rs_level %0b, want %0b",
							nib_bus.rs_level, want.rs));
					if (nib_bus.nibble !== want.nib)
						note_mismatch($sformatf("nibble %h, want %h", nib_bus.nibble, want.nib));
					if (nib_bus.last !== want.last)
						note_mismatch($sformatf("last %0b, want %0b", nib_bus.last, want.last));
				end
			end
			gap_now = sink_gap;
			if (gap_now == 0 && sink_idle_on && $urandom_range(0, 11) == 0)
				gap_now = $urandom_range(1, 16);
			if (hold_left != 0) begin
				nib_bus.ready <= 1'b0;
			end else if (gap_now != 0) begin
				sink_gap      <= gap_now - 1;
				nib_bus.ready <= 1'b0;
			end else begin
				nib_bus.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin : stimulus
		int settle;
		cfg_wr_en <= 1'b0;
		cfg_index <= REG_ENABLE_HIGH;
		cfg_wdata <= '0;
		arst_n    <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// short timing; byte registers left at reset, checked by the first init
		write_reg(REG_ENABLE_HIGH, 20'd1);
		write_reg(REG_SETUP, 20'd0);
		write_reg(REG_POWER_ON, 20'd0);
		src_idle_on  = 1'b1;
		sink_idle_on = 1'b1;
		@(negedge clk);
		queue_cmd(OP_INIT, 1'b0, 8'h00);
		queue_cmd(OP_WRITE, 1'b0, 8'h00);
		queue_cmd(OP_WRITE, 1'b1, 8'hFF);
		queue_cmd(OP_WRITE, 1'b0, 8'hA5);
		queue_cmd(OP_WRITE, 1'b1, 8'h5A);
		queue_cmd(OP_WRITE, 1'b1, 8'h0F);
		queue_cmd(OP_WRITE, 1'b0, 8'hF0);
		queue_cmd(OP_INIT, 1'b1, 8'hFF);
		queue_cmd(OP_WRITE, 1'b1, 8'h80);
		queue_cmd(OP_WRITE, 1'b0, 8'h01);
		wait_idle();

		// long timers, power-on at the top of its range, then replaced before any command
		write_reg(REG_ENABLE_HIGH, 20'd1000000);
		write_reg(REG_POWER_ON, 20'hFFFFF);
		write_reg(REG_ENABLE_HIGH, 20'd3);
		write_reg(REG_POWER_ON, 20'd1000);
		write_reg(REG_SETUP, 20'd1000);
		write_reg(REG_FUNCTION_SET, 20'h00000);
		write_reg(REG_DISPLAY_CTRL, 20'h000FF);
		write_reg(REG_ENTRY_MODE, 20'hABC5A);
		// indexes past the register list are dropped
		write_reg(3'd6, 20'hFFFFF);
		write_reg(3'd7, 20'h55555);
		@(negedge clk);
		queue_cmd(OP_INIT, 1'b1, 8'h3C);
		queue_cmd(OP_WRITE, 1'b1, 8'h00);
		queue_cmd(OP_WRITE, 1'b0, 8'hFF);
		queue_cmd(OP_INIT, 1'b0, 8'h00);
		wait_idle();

		random_config();
		@(negedge clk);
		queue_random(25);
		wait_idle();

		// receiver parks while the source keeps offering back to back
		random_config();
		@(negedge clk);
		src_idle_on  = 1'b0;
		sink_idle_on = 1'b0;
		stall_requests++;
		queue_random(25);
		wait_idle();

		random_config();
		@(negedge clk);
		src_idle_on  = 1'b1;
		sink_idle_on = 1'b1;
		queue_random(25);
		wait_idle();

		random_config();
		@(negedge clk);
		src_idle_on  = 1'b0;
		sink_idle_on = 1'b0;
		queue_random(25);
		wait_idle();

		// let any stray beat show up
		settle = (3 * setup_us + en_high_us) * CPU_US + 32;
		if (settle > 10000)
			settle = 10000;
		repeat (settle) @(posedge clk);
		if (strobes_due.size() != 0)
			note_mismatch($sformatf("%0d nibbles never arrived", strobes_due.size()));
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
`default_nettype wire
